@@ sv/sprite_blit_chroma_scale_core_defines.svh @@
// ----------------------------------------------------------------------------
// sprite blitter assertion macros
// shared concurrent assertion wrappers, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SPRITE_BLIT_CHROMA_SCALE_CORE_DEFINES_SVH
`define SPRITE_BLIT_CHROMA_SCALE_CORE_DEFINES_SVH

// property must hold at every rising edge of i_clk out of reset
`define SBCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define SBCS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

@@ sv/sbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// sbcs_pkg
// shared constants, register map and control types of the sprite blitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbcs_pkg;

    localparam int SCREEN_W  = 240;
    localparam int SCREEN_H  = 240;
    localparam int MAX_SCALE = 8;
    localparam int FB_SIZE   = SCREEN_W * SCREEN_H;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_SPRITE_WIDTH = 3'd0;
    localparam logic [2:0] REG_SCALE_FACTOR = 3'd1;
    localparam logic [2:0] REG_TRANSPARENT  = 3'd2;
    localparam logic [2:0] REG_ORIGIN_ROW   = 3'd3;
    localparam logic [2:0] REG_ORIGIN_COL   = 3'd4;
    localparam logic [2:0] REG_KEY_COLOUR   = 3'd5;

    localparam logic [7:0]  RST_SPRITE_WIDTH = 8'd16;
    localparam logic [3:0]  RST_SCALE_FACTOR = 4'd1;
    localparam logic [15:0] RST_KEY_COLOUR   = 16'h1FF8;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    typedef struct packed {
        logic [7:0]  sprite_width;
        logic [3:0]  scale_factor;
        logic        transparent_mode;
        logic [7:0]  origin_row;
        logic [7:0]  origin_col;
        logic [15:0] key_colour;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic step_ok;
        logic iter_last;
        logic keyed;
    } t_status;

endpackage

@@ sv/sprite_blit_chroma_scale_core.sv @@
// ----------------------------------------------------------------------------
// sprite_blit_chroma_scale_core
// chroma-key sprite blitter with integer scaling, one framebuffer write a beat
// ----------------------------------------------------------------------------
// Source pixels of a square sprite arrive row-major on the input stream; each
// one is expanded into a scale by scale block of framebuffer writes (linear
// address, colour, last-of-pixel flag on tlast, end-of-sprite flag on tuser).
// A pixel that is not keyed occupies the block iterator, one block position per
// cycle, off-screen positions included (they give no beat); a keyed pixel starts
// no block walk. The next pixel is taken in the cycle the last block position is
// issued, so at scale 1 the block sustains one pixel per cycle. Output
// backpressure pauses the iterator. Configure through the apb port only while
// the block is idle.
`timescale 1ns / 1ps
`include "sprite_blit_chroma_scale_core_defines.svh"

module sprite_blit_chroma_scale_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbcs_pkg::DATA_W-1:0]   pwdata,
    output logic [sbcs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // source pixel stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,  // [15:0] pixel
    input  logic                          i_s_tuser,  // [0] first
    // framebuffer write stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,  // [15:0] fb_addr, [31:16] colour
    output logic                          o_m_tlast,  // run_last
    output logic                          o_m_tuser   // [0] sprite_end
);
    import sbcs_pkg::*;

    t_cfg        w_cfg;
    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_state;
    logic [15:0] w_fb_addr;
    logic [15:0] w_colour;

    sbcs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sbcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    sbcs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_pixel      (i_s_tdata),
        .i_first      (i_s_tuser),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_fb_addr    (w_fb_addr),
        .o_colour     (w_colour),
        .o_run_last   (o_m_tlast),
        .o_sprite_end (o_m_tuser)
    );

    assign o_m_tdata = {w_colour, w_fb_addr};

    `SBCS_ASSERT(a_addr_in_fb, o_m_tvalid |-> (o_m_tdata[15:0] < 16'(FB_SIZE)), "fb address out of range")
    `SBCS_ASSERT(a_keyed_stays_idle, (w_cmd.load && w_status.keyed) |=> (w_state == ST_IDLE), "keyed pixel started a block")
    `SBCS_ASSERT_NEVER(a_beat_from_run, $rose(o_m_tvalid) && ($past(w_state) != ST_RUN), "write beat without block walk")

endmodule

@@ sv/sbcs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sbcs_cfg_regs
// apb register file holding sprite geometry, scale and chroma key
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbcs_pkg::DATA_W-1:0]   pwdata,
    output logic [sbcs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sbcs_pkg::t_cfg                o_cfg
);
    import sbcs_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_index;
    logic       w_wr;

    assign w_index = paddr[ADDR_W-1:2];
    assign w_wr    = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_width     <= RST_SPRITE_WIDTH;
            r_cfg.scale_factor     <= RST_SCALE_FACTOR;
            r_cfg.transparent_mode <= 1'b0;
            r_cfg.origin_row       <= 8'd0;
            r_cfg.origin_col       <= 8'd0;
            r_cfg.key_colour       <= RST_KEY_COLOUR;
        end else if (w_wr) begin
            unique case (w_index)
                REG_SPRITE_WIDTH: r_cfg.sprite_width     <= pwdata[7:0];
                REG_SCALE_FACTOR: r_cfg.scale_factor     <= pwdata[3:0];
                REG_TRANSPARENT:  r_cfg.transparent_mode <= pwdata[0];
                REG_ORIGIN_ROW:   r_cfg.origin_row       <= pwdata[7:0];
                REG_ORIGIN_COL:   r_cfg.origin_col       <= pwdata[7:0];
                REG_KEY_COLOUR:   r_cfg.key_colour       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_SPRITE_WIDTH: prdata = {24'd0, r_cfg.sprite_width};
            REG_SCALE_FACTOR: prdata = {28'd0, r_cfg.scale_factor};
            REG_TRANSPARENT:  prdata = {31'd0, r_cfg.transparent_mode};
            REG_ORIGIN_ROW:   prdata = {24'd0, r_cfg.origin_row};
            REG_ORIGIN_COL:   prdata = {24'd0, r_cfg.origin_col};
            REG_KEY_COLOUR:   prdata = {16'd0, r_cfg.key_colour};
            default:          prdata = '0;
        endcase
    end

endmodule

@@ sv/sbcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbcs_ctrl
// sequencer fsm: takes a pixel and, unless it is keyed, walks its scale by scale block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  sbcs_pkg::t_status i_status,
    output sbcs_pkg::t_cmd    o_cmd,
    output logic              o_state
);
    import sbcs_pkg::*;

    logic r_state;
    logic n_state;
    logic w_done;

    // last block position issued this cycle
    assign w_done     = (r_state == ST_RUN) && i_status.step_ok && i_status.iter_last;
    assign o_s_tready = (r_state == ST_IDLE) || w_done;
    assign o_cmd.load = i_s_tvalid && o_s_tready;
    assign o_cmd.step = (r_state == ST_RUN) && i_status.step_ok;
    assign o_state    = r_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = i_status.keyed ? ST_IDLE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_done) begin
                    if (o_cmd.load && !i_status.keyed) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/sbcs_datapath.sv @@
// ----------------------------------------------------------------------------
// sbcs_datapath
// source counters, block position iterator, address generation, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcs_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbcs_pkg::t_cfg    i_cfg,
    input  sbcs_pkg::t_cmd    i_cmd,
    output sbcs_pkg::t_status o_status,
    input  logic [15:0]       i_pixel,
    input  logic              i_first,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [15:0]       o_fb_addr,
    output logic [15:0]       o_colour,
    output logic              o_run_last,
    output logic              o_sprite_end
);
    import sbcs_pkg::*;

    localparam logic [3:0]  SCALE_MAX = 4'(MAX_SCALE);
    localparam logic [11:0] ROW_LIM   = 12'(SCREEN_H);
    localparam logic [11:0] COL_LIM   = 12'(SCREEN_W);

    // source position counters
    logic [7:0]  r_src_row;
    logic [7:0]  r_src_col;
    // current pixel and block iterator
    logic [15:0] r_pix;
    logic        r_end;
    logic [11:0] r_row;
    logic [11:0] r_col;
    logic [11:0] r_col_base;
    logic [2:0]  r_si;
    logic [2:0]  r_sj;
    logic [2:0]  r_scale_m1;
    // output register
    logic        r_out_valid;
    logic [15:0] r_fb_addr;
    logic [15:0] r_colour;
    logic        r_run_last;
    logic        r_sprite_end;

    logic [7:0]  w_width;
    logic [3:0]  w_scale;
    logic [7:0]  w_cur_row;
    logic [7:0]  w_cur_col;
    logic [8:0]  w_col_inc;
    logic [8:0]  w_row_inc;
    logic        w_end;
    logic [7:0]  n_src_row;
    logic [7:0]  n_src_col;
    logic [11:0] w_base_r;
    logic [11:0] w_base_c;
    logic        w_wr_ok;
    logic        w_last_row;
    logic        w_last_col;
    logic        w_row_end;
    logic [15:0] w_addr;

    assign w_width   = (i_cfg.sprite_width == 8'd0) ? 8'd1 : i_cfg.sprite_width;
    assign w_scale   = (i_cfg.scale_factor == 4'd0) ? 4'd1 :
                       (i_cfg.scale_factor > SCALE_MAX) ? SCALE_MAX : i_cfg.scale_factor;
    assign w_cur_row = i_first ? 8'd0 : r_src_row;
    assign w_cur_col = i_first ? 8'd0 : r_src_col;
    assign w_col_inc = {1'b0, w_cur_col} + 9'd1;
    assign w_row_inc = {1'b0, w_cur_row} + 9'd1;
    assign w_end     = (w_col_inc >= {1'b0, w_width}) && (w_row_inc >= {1'b0, w_width});

    always_comb begin
        n_src_col = w_col_inc[7:0];
        n_src_row = w_cur_row;
        if (w_col_inc >= {1'b0, w_width}) begin
            n_src_col = 8'd0;
            n_src_row = (w_row_inc >= {1'b0, w_width}) ? 8'd0 : w_row_inc[7:0];
        end
    end

    assign w_base_r = 12'(i_cfg.origin_row) + 12'({4'd0, w_cur_row} * {8'd0, w_scale});
    assign w_base_c = 12'(i_cfg.origin_col) + 12'({4'd0, w_cur_col} * {8'd0, w_scale});

    assign w_wr_ok    = (r_row < ROW_LIM) && (r_col < COL_LIM);
    assign w_last_row = (r_si == r_scale_m1) || (r_row == ROW_LIM - 12'd1);
    assign w_last_col = (r_sj == r_scale_m1) || (r_col == COL_LIM - 12'd1);
    assign w_row_end  = (r_sj == r_scale_m1);
    assign w_addr     = 16'(r_row) * 16'(SCREEN_W) + 16'(r_col);

    assign o_status.step_ok   = !r_out_valid || i_m_tready;
    assign o_status.iter_last = (r_si == r_scale_m1) && (r_sj == r_scale_m1);
    assign o_status.keyed     = i_cfg.transparent_mode && (i_pixel == i_cfg.key_colour);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_row <= 8'd0;
            r_src_col <= 8'd0;
        end else if (i_cmd.load) begin
            r_src_row <= n_src_row;
            r_src_col <= n_src_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix      <= i_pixel;
            r_end      <= w_end;
            r_row      <= w_base_r;
            r_col      <= w_base_c;
            r_col_base <= w_base_c;
            r_si       <= 3'd0;
            r_sj       <= 3'd0;
            r_scale_m1 <= 3'(w_scale - 4'd1);
        end else if (i_cmd.step) begin
            if (w_row_end) begin
                r_sj  <= 3'd0;
                r_si  <= r_si + 3'd1;
                r_row <= r_row + 12'd1;
                r_col <= r_col_base;
            end else begin
                r_sj  <= r_sj + 3'd1;
                r_col <= r_col + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && w_wr_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_wr_ok) begin
            r_fb_addr    <= w_addr;
            r_colour     <= r_pix;
            r_run_last   <= w_last_row && w_last_col;
            r_sprite_end <= r_end;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_fb_addr    = r_fb_addr;
    assign o_colour     = r_colour;
    assign o_run_last   = r_run_last;
    assign o_sprite_end = r_sprite_end;

endmodule
